// ----- sv/lbmf_pkg.sv -----
// ----------------------------------------------------------------------------
// lbmf_pkg
// Shared widths, item kinds, register indexes and reset values for the laser
// background mask filter.
// ----------------------------------------------------------------------------
package lbmf_pkg;

	localparam int BEAM_COUNT_DEFAULT = 1024;

	localparam int KIND_W  = 2;
	localparam int BEAM_W  = 10;
	localparam int RANGE_W = 16;
	localparam int INTEN_W = 16;
	localparam int TRIG_W  = 16;
	localparam int COORD_W = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FILTER = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTEN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BG_MARGIN   = 3'd7;

	// Register reset values
	localparam logic [RANGE_W-1:0] RANGE_LOWER_RST = 16'd0;
	localparam logic [RANGE_W-1:0] RANGE_UPPER_RST = 16'hFFFF;
	localparam logic [COORD_W-1:0] BOX_LOW_RST     = 17'h10000;
	localparam logic [COORD_W-1:0] BOX_HIGH_RST    = 17'h0FFFF;
	localparam logic [INTEN_W-1:0] MIN_INTEN_RST   = 16'd0;
	localparam logic [RANGE_W-1:0] BG_MARGIN_RST   = 16'd0;

	// One background entry: mask bit and the smallest learned range
	typedef struct packed {
		logic               present;
		logic [RANGE_W-1:0] range;
	} bg_entry_t;

	// One trig entry: Q1.15 cosine and sine
	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_entry_t;

endpackage

// ----- sv/laser_background_mask_filter.sv -----
// ----------------------------------------------------------------------------
// laser_background_mask_filter
// Per-beam background subtraction and box filter for laser range samples.
// Load requests fill a beam's trig entry, learn requests keep the smallest
// valid range per beam, filter requests give a point in x and y when it is
// not background, lies in the box and is bright enough.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+----------
//  in      | kind beam range_mm intensity cos/sin_value| into      | valid/ready
//  out     | point_beam point_x/y point_range/intensity| out of    | valid/ready
//  cfg     | cfg_we cfg_index cfg_data                 | into      | write only
//
//  One request is taken per cycle unless clearing or an output stall holds it.
//  The accepting edge loads the input register and the memory reads; multiply,
//  box and threshold tests load a kept point into the output register (out_valid).
//  After reset a clearing pass walks the background memory, one entry a
//  cycle, over all BEAM_COUNT entries; in_ready stays low during it.
//  A stalled output holds a point to keep in the input register and drops
//  in_ready; load, learn and dropped requests never wait on the output side.
//
module laser_background_mask_filter #(
	parameter int BEAM_COUNT = lbmf_pkg::BEAM_COUNT_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [lbmf_pkg::KIND_W-1:0]            kind,
	input  logic [lbmf_pkg::BEAM_W-1:0]            beam,
	input  logic [lbmf_pkg::RANGE_W-1:0]           range_mm,
	input  logic [lbmf_pkg::INTEN_W-1:0]           intensity,
	input  logic signed [lbmf_pkg::TRIG_W-1:0]     cos_value,
	input  logic signed [lbmf_pkg::TRIG_W-1:0]     sin_value,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lbmf_pkg::BEAM_W-1:0]            point_beam,
	output logic signed [lbmf_pkg::COORD_W-1:0]    point_x,
	output logic signed [lbmf_pkg::COORD_W-1:0]    point_y,
	output logic [lbmf_pkg::RANGE_W-1:0]           point_range,
	output logic [lbmf_pkg::INTEN_W-1:0]           point_intensity,
	// configuration
	input  logic                                   cfg_we,
	input  logic [lbmf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lbmf_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int ADDR_W = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;
	localparam int PROD_W = lbmf_pkg::RANGE_W + 1 + lbmf_pkg::TRIG_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [lbmf_pkg::RANGE_W-1:0]        range_lower_q;
	logic [lbmf_pkg::RANGE_W-1:0]        range_upper_q;
	logic signed [lbmf_pkg::COORD_W-1:0] box_x_low_q;
	logic signed [lbmf_pkg::COORD_W-1:0] box_x_high_q;
	logic signed [lbmf_pkg::COORD_W-1:0] box_y_low_q;
	logic signed [lbmf_pkg::COORD_W-1:0] box_y_high_q;
	logic [lbmf_pkg::INTEN_W-1:0]        min_inten_q;
	logic [lbmf_pkg::RANGE_W-1:0]        bg_margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lower_q <= lbmf_pkg::RANGE_LOWER_RST;
			range_upper_q <= lbmf_pkg::RANGE_UPPER_RST;
			box_x_low_q   <= lbmf_pkg::BOX_LOW_RST;
			box_x_high_q  <= lbmf_pkg::BOX_HIGH_RST;
			box_y_low_q   <= lbmf_pkg::BOX_LOW_RST;
			box_y_high_q  <= lbmf_pkg::BOX_HIGH_RST;
			min_inten_q   <= lbmf_pkg::MIN_INTEN_RST;
			bg_margin_q   <= lbmf_pkg::BG_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lbmf_pkg::REG_RANGE_LOWER: range_lower_q <= cfg_data[lbmf_pkg::RANGE_W-1:0];
				lbmf_pkg::REG_RANGE_UPPER: range_upper_q <= cfg_data[lbmf_pkg::RANGE_W-1:0];
				lbmf_pkg::REG_BOX_X_LOW:   box_x_low_q   <= cfg_data;
				lbmf_pkg::REG_BOX_X_HIGH:  box_x_high_q  <= cfg_data;
				lbmf_pkg::REG_BOX_Y_LOW:   box_y_low_q   <= cfg_data;
				lbmf_pkg::REG_BOX_Y_HIGH:  box_y_high_q  <= cfg_data;
				lbmf_pkg::REG_MIN_INTEN:   min_inten_q   <= cfg_data[lbmf_pkg::INTEN_W-1:0];
				lbmf_pkg::REG_BG_MARGIN:   bg_margin_q   <= cfg_data[lbmf_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Clearing pass over the background mask after reset
	// ------------------------------------------------------------------
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(BEAM_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic cand_s1;       // stage 1 request becomes a filter candidate
	logic keep_s1;       // stage 1 candidate also passes the box
	logic s1_adv;
	logic out_free;
	logic accept;

	assign out_free = !out_valid_q || out_ready;
	// load, learn and dropped requests leave stage 1 at once; only points wait
	assign s1_adv   = valid_s1 && (!keep_s1 || out_free);
	assign in_ready = !clearing_q && (!valid_s1 || s1_adv);
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Stage 1: input register plus registered memory reads
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]            in_addr;
	logic                         in_live;
	logic [lbmf_pkg::KIND_W-1:0]  kind_s1;
	logic [lbmf_pkg::BEAM_W-1:0]  beam_s1;
	logic [ADDR_W-1:0]            addr_s1;
	logic                         live_s1;
	logic [lbmf_pkg::RANGE_W-1:0] range_s1;
	logic [lbmf_pkg::INTEN_W-1:0] inten_s1;
	lbmf_pkg::bg_entry_t          bg_s1;
	lbmf_pkg::trig_entry_t        trig_s1;

	assign in_addr = ADDR_W'(beam);
	assign in_live = (32'(beam) < 32'(BEAM_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			beam_s1  <= beam;
			addr_s1  <= in_addr;
			live_s1  <= in_live;
			range_s1 <= range_mm;
			inten_s1 <= intensity;
		end
	end

	// Stage 1 decisions
	logic                  range_ok;
	logic                  is_bg;
	logic                  learn_we;
	logic                  load_we;
	lbmf_pkg::bg_entry_t   learn_wdata;
	lbmf_pkg::trig_entry_t load_wdata;

	assign range_ok = (range_s1 > range_lower_q) && (range_s1 < range_upper_q);
	// background when stored - margin < range, i.e. stored < range + margin
	assign is_bg = bg_s1.present &&
		({1'b0, bg_s1.range} < ({1'b0, range_s1} + {1'b0, bg_margin_q}));

	assign learn_we = s1_adv && live_s1 && (kind_s1 == lbmf_pkg::KIND_LEARN) && range_ok &&
		(!bg_s1.present || (bg_s1.range > range_s1));
	assign learn_wdata.present = 1'b1;
	assign learn_wdata.range   = range_s1;

	assign cand_s1 = live_s1 && (kind_s1 == lbmf_pkg::KIND_FILTER) && range_ok && !is_bg &&
		(inten_s1 >= min_inten_q);

	// ------------------------------------------------------------------
	// Background memory: clearing pass or learn writes, one read on accept
	// ------------------------------------------------------------------
	lbmf_pkg::bg_entry_t bg_mem [BEAM_COUNT];
	logic                bg_we;
	logic [ADDR_W-1:0]   bg_waddr;
	lbmf_pkg::bg_entry_t bg_wdata;

	assign bg_we    = clearing_q || learn_we;
	assign bg_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign bg_wdata = clearing_q ? '0 : learn_wdata;

	always_ff @(posedge clk) begin
		if (bg_we) begin
			bg_mem[bg_waddr] <= bg_wdata;
		end
		if (accept) begin
			// forward a learn write to the same beam taken in this cycle
			if (learn_we && (addr_s1 == in_addr)) begin
				bg_s1 <= learn_wdata;
			end else begin
				bg_s1 <= bg_mem[in_addr];
			end
		end
	end

	// ------------------------------------------------------------------
	// Trig memory: load writes, one read on accept
	// ------------------------------------------------------------------
	lbmf_pkg::trig_entry_t trig_mem [BEAM_COUNT];
	lbmf_pkg::trig_entry_t load_data_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			load_data_s1.cos_v <= cos_value;
			load_data_s1.sin_v <= sin_value;
		end
	end

	assign load_we    = s1_adv && live_s1 && (kind_s1 == lbmf_pkg::KIND_LOAD);
	assign load_wdata = load_data_s1;

	always_ff @(posedge clk) begin
		if (load_we) begin
			trig_mem[addr_s1] <= load_wdata;
		end
		if (accept) begin
			if (load_we && (addr_s1 == in_addr)) begin
				trig_s1 <= load_wdata;
			end else begin
				trig_s1 <= trig_mem[in_addr];
			end
		end
	end

	// ------------------------------------------------------------------
	// Scaled coordinates and box test
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0]            prod_x;
	logic signed [PROD_W-1:0]            prod_y;
	logic signed [lbmf_pkg::COORD_W-1:0] x_scaled;
	logic signed [lbmf_pkg::COORD_W-1:0] y_scaled;

	assign prod_x = $signed({1'b0, range_s1}) * trig_s1.cos_v;
	assign prod_y = $signed({1'b0, range_s1}) * trig_s1.sin_v;

	// drop 15 fraction bits; the select floors toward minus infinity
	assign x_scaled = prod_x[PROD_W-2:15];
	assign y_scaled = prod_y[PROD_W-2:15];

	assign keep_s1 = cand_s1 &&
		(x_scaled >= box_x_low_q) && (x_scaled <= box_x_high_q) &&
		(y_scaled >= box_y_low_q) && (y_scaled <= box_y_high_q);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic                                out_load;
	logic [lbmf_pkg::BEAM_W-1:0]         point_beam_q;
	logic signed [lbmf_pkg::COORD_W-1:0] point_x_q;
	logic signed [lbmf_pkg::COORD_W-1:0] point_y_q;
	logic [lbmf_pkg::RANGE_W-1:0]        point_range_q;
	logic [lbmf_pkg::INTEN_W-1:0]        point_inten_q;

	assign out_load = s1_adv && keep_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			point_beam_q  <= beam_s1;
			point_x_q     <= x_scaled;
			point_y_q     <= y_scaled;
			point_range_q <= range_s1;
			point_inten_q <= inten_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign point_beam      = point_beam_q;
	assign point_x         = point_x_q;
	assign point_y         = point_y_q;
	assign point_range     = point_range_q;
	assign point_intensity = point_inten_q;

endmodule

// ----- tb/sv/laser_background_mask_filter_test.sv -----
// ----------------------------------------------------------------------------
// laser_background_mask_filter_test
// Self-checking bench for the laser background mask filter. A scoreboard class
// tracks the per-beam trig and background tables along with the register
// settings. It predicts the kept point of every accepted request and checks
// each point that leaves the block, in order and field by field. Stimulus is a
// short directed sweep, then random request streams under several register
// settings, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module laser_background_mask_filter_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [lbmf_pkg::KIND_W-1:0]         kind_t;
	typedef logic [lbmf_pkg::BEAM_W-1:0]         beam_t;
	typedef logic [lbmf_pkg::RANGE_W-1:0]        range_t;
	typedef logic [lbmf_pkg::INTEN_W-1:0]        inten_t;
	typedef logic signed [lbmf_pkg::TRIG_W-1:0]  trig_t;
	typedef logic signed [lbmf_pkg::COORD_W-1:0] coord_t;
	typedef logic [lbmf_pkg::CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [lbmf_pkg::CFG_DATA_W-1:0]     cfg_data_t;

	// Kind code the block must take and ignore
	localparam kind_t KIND_UNUSED = 2'd3;

	localparam int BEAMS          = lbmf_pkg::BEAM_COUNT_DEFAULT;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_OFF       = 400;  // long output stall, in cycles
	localparam int SETTLE_CYCLES  = 8;    // covers the two-register pipeline
	// Cycles with no request moving on either channel before giving up; sized
	// above the background clearing pass after reset and the long stall.
	localparam int STALL_LIMIT    = 5000;

	typedef struct packed {
		beam_t  beam;
		coord_t x;
		coord_t y;
		range_t rng;
		inten_t inten;
	} point_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the beam tables and registers, predicts kept points
	// ------------------------------------------------------------------------
	class point_scoreboard;
		range_t                    range_lower;
		range_t                    range_upper;
		inten_t                    min_intensity;
		range_t                    bg_margin;
		int                        box_x_low;
		int                        box_x_high;
		int                        box_y_low;
		int                        box_y_high;
		bit                        bg_present [BEAMS];
		range_t                    bg_range [BEAMS];
		trig_t                     beam_cos [BEAMS];
		trig_t                     beam_sin [BEAMS];
		point_t                    kept_points [$];
		int                        mismatches;
		int                        checked;

		function new();
			range_lower   = lbmf_pkg::RANGE_LOWER_RST;
			range_upper   = lbmf_pkg::RANGE_UPPER_RST;
			min_intensity = lbmf_pkg::MIN_INTEN_RST;
			bg_margin     = lbmf_pkg::BG_MARGIN_RST;
			box_x_low     = int'($signed(lbmf_pkg::BOX_LOW_RST));
			box_x_high    = int'($signed(lbmf_pkg::BOX_HIGH_RST));
			box_y_low     = int'($signed(lbmf_pkg::BOX_LOW_RST));
			box_y_high    = int'($signed(lbmf_pkg::BOX_HIGH_RST));
			foreach (bg_present[n])
				bg_present[n] = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_register(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				lbmf_pkg::REG_RANGE_LOWER: range_lower   = data[lbmf_pkg::RANGE_W-1:0];
				lbmf_pkg::REG_RANGE_UPPER: range_upper   = data[lbmf_pkg::RANGE_W-1:0];
				lbmf_pkg::REG_BOX_X_LOW:   box_x_low     = int'($signed(data));
				lbmf_pkg::REG_BOX_X_HIGH:  box_x_high    = int'($signed(data));
				lbmf_pkg::REG_BOX_Y_LOW:   box_y_low     = int'($signed(data));
				lbmf_pkg::REG_BOX_Y_HIGH:  box_y_high    = int'($signed(data));
				lbmf_pkg::REG_MIN_INTEN:   min_intensity = data[lbmf_pkg::INTEN_W-1:0];
				lbmf_pkg::REG_BG_MARGIN:   bg_margin     = data[lbmf_pkg::RANGE_W-1:0];
				default: ;
			endcase
		endfunction

		// Range times a Q1.15 factor, floored
		function coord_t scale_q15(range_t r, trig_t t);
			longint p;
			p = longint'(r) * longint'(t);
			return coord_t'(p >>> 15);
		endfunction

		function void note_request(kind_t k, beam_t b, range_t r, inten_t i,
				trig_t c, trig_t s);
			bit     in_window;
			bit     background;
			point_t p;
			in_window = (r > range_lower) && (r < range_upper);
			case (k)
				lbmf_pkg::KIND_LOAD: begin
					beam_cos[b] = c;
					beam_sin[b] = s;
				end
				lbmf_pkg::KIND_LEARN: begin
					if (in_window && (!bg_present[b] || bg_range[b] > r)) begin
						bg_range[b] = r;
						bg_present[b] = 1'b1;
					end
				end
				lbmf_pkg::KIND_FILTER: begin
					background = bg_present[b] &&
						(int'(bg_range[b]) - int'(bg_margin) < int'(r));
					if (in_window && !background) begin
						p.beam  = b;
						p.x     = scale_q15(r, beam_cos[b]);
						p.y     = scale_q15(r, beam_sin[b]);
						p.rng   = r;
						p.inten = i;
						if (p.x >= box_x_low && p.x <= box_x_high &&
								p.y >= box_y_low && p.y <= box_y_high && i >= min_intensity)
							kept_points = {kept_points, p};
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				mismatches++;
				$display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_point(point_t got);
			point_t want;
			checked++;
			if (kept_points.size() == 0) begin
				mismatches++;
				$display("%t: point on beam %0d (x %0d, y %0d), expected none, actual one",
					$time, got.beam, got.x, got.y);
				return;
			end
			want = kept_points.pop_front();
			compare_field("point_beam", longint'(want.beam), longint'(got.beam));
			compare_field("point_x", longint'(want.x), longint'(got.x));
			compare_field("point_y", longint'(want.y), longint'(got.y));
			compare_field("point_range", longint'(want.rng), longint'(got.rng));
			compare_field("point_intensity", longint'(want.inten), longint'(got.inten));
		endfunction

		function int pending();
			return kept_points.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block signals; every input holds a known value from time zero
	// ------------------------------------------------------------------------
	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	kind_t                     kind = lbmf_pkg::KIND_LOAD;
	beam_t                     beam = '0;
	range_t                    range_mm = '0;
	inten_t                    intensity = '0;
	trig_t                     cos_value = '0;
	trig_t                     sin_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	beam_t                     point_beam;
	coord_t                    point_x;
	coord_t                    point_y;
	range_t                    point_range;
	inten_t                    point_intensity;
	logic                      cfg_we = 1'b0;
	cfg_idx_t                  cfg_index = '0;
	cfg_data_t                 cfg_data = '0;

	point_scoreboard point_sb = new();

	bit steady = 1'b0;             // both sides drop their gaps while set
	bit sink_hold_request = 1'b0;  // ask the receiver for one long stall
	bit trig_loaded [BEAMS];       // filter only beams with trig in place
	int loaded_beams [$];          // in load order; the first few are the hot set
	int kind_count [4];
	int setting_count = 1;         // reset values count as the first setting

	laser_background_mask_filter #(
		.BEAM_COUNT(BEAMS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.beam            (beam),
		.range_mm        (range_mm),
		.intensity       (intensity),
		.cos_value       (cos_value),
		.sin_value       (sin_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.point_beam      (point_beam),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_range     (point_range),
		.point_intensity (point_intensity),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Request side. Drive at the rising edge, sample ready at the falling edge
	// so the handshake never depends on event order within a time step.
	// ------------------------------------------------------------------------
	task automatic send_request(input kind_t k, input beam_t b, input range_t r,
			input inten_t i, input trig_t c, input trig_t s);
		int gap;
		bit took;
		gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
		// Drop valid only for a real gap; back to back it stays high
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		beam      <= b;
		range_mm  <= r;
		intensity <= i;
		cos_value <= c;
		sin_value <= s;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		point_sb.note_request(k, b, r, i, c, s);
		kind_count[k]++;
		if (k == lbmf_pkg::KIND_LOAD && !trig_loaded[b]) begin
			trig_loaded[b] = 1'b1;
			loaded_beams = {loaded_beams, int'(b)};
		end
	endtask

	// Hold until every predicted point is out, then let the pipeline empty so
	// load, learn and dropped filter requests have also passed through.
	task automatic settle();
		in_valid <= 1'b0;
		while (point_sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[lbmf_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		point_sb.set_register(idx, value[lbmf_pkg::CFG_DATA_W-1:0]);
	endtask

	// Write all eight registers; call only with the block idle
	task automatic apply_settings(input int lo, input int hi, input int xl, input int xh,
			input int yl, input int yh, input int min_i, input int margin);
		write_register(lbmf_pkg::REG_RANGE_LOWER, lo);
		write_register(lbmf_pkg::REG_RANGE_UPPER, hi);
		write_register(lbmf_pkg::REG_BOX_X_LOW, xl);
		write_register(lbmf_pkg::REG_BOX_X_HIGH, xh);
		write_register(lbmf_pkg::REG_BOX_Y_LOW, yl);
		write_register(lbmf_pkg::REG_BOX_Y_HIGH, yh);
		write_register(lbmf_pkg::REG_MIN_INTEN, min_i);
		write_register(lbmf_pkg::REG_BG_MARGIN, margin);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	function automatic int clamp16(int v);
		return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
	endfunction

	// Mostly the hot set so learn and filter requests keep hitting the same
	// beams; now and then any beam with trig loaded.
	function automatic beam_t pick_beam();
		int n;
		n = loaded_beams.size();
		if ($urandom_range(0, 3) != 0)
			return beam_t'(loaded_beams[$urandom_range(0, ((n < 16) ? n : 16) - 1)]);
		return beam_t'(loaded_beams[$urandom_range(0, n - 1)]);
	endfunction

	// Aim ranges at the window edges and at the background threshold
	function automatic range_t pick_range(beam_t b);
		int base;
		int lo;
		int hi;
		int pick;
		pick = int'($urandom_range(0, 5));
		if (pick == 0)
			return range_t'($urandom);
		if (pick == 1 || pick == 2) begin
			base = (pick == 1) ? int'(point_sb.range_lower) : int'(point_sb.range_upper);
			base += int'($urandom_range(0, 2));
			base -= 1;
			return range_t'(clamp16(base));
		end
		if (pick != 5 && point_sb.bg_present[b]) begin
			base = int'(point_sb.bg_range[b]);
			base -= int'(point_sb.bg_margin);
			base += int'($urandom_range(0, 4));
			base -= 2;
			return range_t'(clamp16(base));
		end
		lo = int'(point_sb.range_lower);
		hi = int'(point_sb.range_upper);
		lo += 1;
		hi -= 1;
		if (lo <= hi)
			return range_t'($urandom_range(lo, hi));
		return range_t'($urandom);
	endfunction

	function automatic inten_t pick_intensity();
		int base;
		if ($urandom_range(0, 1) != 0)
			return inten_t'($urandom);
		base = int'(point_sb.min_intensity);
		base += int'($urandom_range(0, 2));
		base -= 1;
		return inten_t'(clamp16(base));
	endfunction

	function automatic trig_t pick_trig();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return trig_t'($urandom);
		endcase
	endfunction

	task automatic random_request();
		int pick;
		kind_t k;
		beam_t b;
		pick = int'($urandom_range(0, 99));
		if (pick < 12)
			k = lbmf_pkg::KIND_LOAD;
		else if (pick < 37)
			k = lbmf_pkg::KIND_LEARN;
		else if (pick < 95)
			k = lbmf_pkg::KIND_FILTER;
		else
			k = KIND_UNUSED;
		b = pick_beam();
		// Spread loads over the whole table; reloads of hot beams swap trig
		if (k == lbmf_pkg::KIND_LOAD && $urandom_range(0, 1) != 0)
			b = beam_t'($urandom);
		if (k == KIND_UNUSED || (k == lbmf_pkg::KIND_LEARN && $urandom_range(0, 7) == 0))
			b = beam_t'($urandom);
		send_request(k, b, pick_range(b), pick_intensity(), pick_trig(), pick_trig());
	endtask

	task automatic run_phase(input int count, input bit calm);
		steady = calm;
		repeat (count) random_request();
		steady = 1'b0;
		settle();
	endtask

	// ------------------------------------------------------------------------
	// Point side: random stall per point, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : point_sink
		point_t seen;
		int stall;
		bit took;
		forever begin
			if (sink_hold_request)
				stall = HOLD_OFF;
			else
				stall = steady ? 0 : int'($urandom_range(0, MAX_GAP));
			sink_hold_request = 1'b0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid;
				seen.beam  = point_beam;
				seen.x     = point_x;
				seen.y     = point_y;
				seen.rng   = point_range;
				seen.inten = point_intensity;
				@(posedge clk);
			end while (!took);
			point_sb.check_point(seen);
		end
	end

	// End the run when neither channel has moved for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sweep under reset settings. Trig extremes, floor rounding of
		// negative products, exclusive window edges, learn keeping the smallest
		// range, the background threshold on both sides, the unused kind, and
		// requests that touch a beam right after it was written.
		send_request(lbmf_pkg::KIND_LOAD, 10'd0, 16'd0, 16'd0, 16'sh7FFF, 16'sh0000);
		send_request(lbmf_pkg::KIND_LOAD, 10'd1, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh8000);
		send_request(lbmf_pkg::KIND_LOAD, 10'd1023, 16'd12345, 16'd54321, -16'sd1, 16'sd1);
		send_request(lbmf_pkg::KIND_LOAD, 10'd5, 16'd0, 16'd0, 16'sd23170, -16'sd23170);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'd65534, 16'hFFFF, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'hFFFF, 16'd100, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'd0, 16'd100, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd1, 16'd1, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd1, 16'd65534, 16'd7, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd1023, 16'd3, 16'd9, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LEARN, 10'd5, 16'd1000, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LEARN, 10'd5, 16'd2000, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LEARN, 10'd5, 16'hFFFF, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd5, 16'd1000, 16'd50, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd5, 16'd1001, 16'd50, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd5, 16'd999, 16'd50, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LEARN, 10'd5, 16'd500, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd5, 16'd600, 16'd50, 16'sh0000, 16'sh0000);
		send_request(KIND_UNUSED, 10'd1023, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1);
		send_request(KIND_UNUSED, 10'd0, 16'd0, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LEARN, 10'd0, 16'd300, 16'd0, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'd301, 16'd1, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'd300, 16'd1, 16'sh0000, 16'sh0000);
		send_request(lbmf_pkg::KIND_LOAD, 10'd0, 16'd0, 16'd0, 16'sh0000, 16'sh7FFF);
		send_request(lbmf_pkg::KIND_FILTER, 10'd0, 16'd299, 16'd2, 16'sh0000, 16'sh0000);
		settle();

		// Back pressure: the receiver stalls for a long stretch while requests
		// that all produce points keep coming, so the pipeline fills and the
		// input stalls. Beams 1 and 1023 have no background entry.
		steady = 1'b1;
		sink_hold_request = 1'b1;
		repeat (40)
			send_request(lbmf_pkg::KIND_FILTER,
				($urandom_range(0, 1) != 0) ? 10'd1 : 10'd1023,
				range_t'($urandom_range(1, 65534)), inten_t'($urandom),
				16'sh0000, 16'sh0000);
		steady = 1'b0;
		settle();

		// Moderate window and box
		apply_settings(100, 60000, -20000, 20000, -20000, 20000, 1000, 50);
		run_phase(250, 1'b0);

		// Inverted extremes: nothing is in the window and nothing passes
		apply_settings(65535, 0, 65535, -65536, 65535, -65536, 65535, 65535);
		run_phase(60, 1'b0);

		// Full window, largest margin: any beam with an entry is background
		apply_settings(0, 65535, -65536, 65535, -65536, 65535, 0, 65535);
		run_phase(150, 1'b1);

		// Short ranges, tight box, high intensity threshold
		apply_settings(10, 2000, -500, 500, -500, 500, 30000, 200);
		run_phase(150, 1'b0);

		// Single valid range value
		apply_settings(999, 1001, -65536, 65535, -65536, 65535, 0, 0);
		run_phase(60, 1'b0);

		// Random settings
		for (int n = 0; n < 4; n++) begin
			apply_settings(int'($urandom_range(0, 2000)), int'($urandom_range(20000, 65535)),
				-int'($urandom_range(0, 65536)), int'($urandom_range(0, 65535)),
				-int'($urandom_range(0, 65536)), int'($urandom_range(0, 65535)),
				int'($urandom_range(0, 40000)), int'($urandom_range(0, 3000)));
			run_phase(100, n == 2);
		end

		$display("Covered %0d load, %0d learn, %0d filter and %0d unused-kind requests",
			kind_count[lbmf_pkg::KIND_LOAD], kind_count[lbmf_pkg::KIND_LEARN],
			kind_count[lbmf_pkg::KIND_FILTER], kind_count[KIND_UNUSED]);
		$display("under %0d register settings; %0d points checked, %0d mismatches",
			setting_count, point_sb.checked, point_sb.mismatches);
		if (point_sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
